// ----- hw/rtl/qcg_pkg.sv -----
// ----------------------------------------------------------------------------
// qcg_pkg
// Shared widths, configuration and control types, and the constant tables of
// the creep gait offset unit.
// ----------------------------------------------------------------------------
package qcg_pkg;

  localparam int PHASES_DEF = 10;

  localparam int PHASE_W    = 4;
  localparam int DIR_W      = 9;
  localparam int STEP_W     = 8;
  localparam int LEAN_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int LEG_W      = 2;
  localparam int OFS_W      = 18;
  localparam int Z_W        = 7;

  localparam int LEAN_UNITS = 20;
  localparam int LIFT_Z     = -40;

  localparam int TAB_W      = 16;
  localparam int TRIG_W     = 17;
  localparam int M_W        = 6;
  localparam int SM_W       = STEP_W + 1 + M_W;
  localparam int N_W        = SM_W + TRIG_W;
  localparam int B_W        = 20;
  localparam int Q_W        = B_W + 1;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W    = 24;

  localparam logic [DIR_W-1:0] DIR_LIMIT = 9'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALK_DIR = 2'd0,
    REG_STEP_LEN = 2'd1,
    REG_LEAN_PAT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic [STEP_W-1:0] step;
    logic [LEAN_W-1:0] lean;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic             last;
    logic             lift;
    logic [LEG_W-1:0] leg;
  } ctl_t;

  function automatic logic [3:0] lift_slot(input logic [1:0] sector,
                                           input logic [LEG_W-1:0] leg);
    logic [3:0] s;
    begin
      case ({sector, leg})
        4'h0: s = 4'd8;  4'h1: s = 4'd3;  4'h2: s = 4'd0;  4'h3: s = 4'd5;
        4'h4: s = 4'd3;  4'h5: s = 4'd5;  4'h6: s = 4'd8;  4'h7: s = 4'd0;
        4'h8: s = 4'd5;  4'h9: s = 4'd0;  4'hA: s = 4'd3;  4'hB: s = 4'd8;
        4'hC: s = 4'd0;  4'hD: s = 4'd8;  4'hE: s = 4'd5;  4'hF: s = 4'd3;
        default: s = 4'd0;
      endcase
      return s;
    end
  endfunction

  function automatic logic [TAB_W-1:0] sine_q15(input logic [6:0] idx);
    logic [TAB_W-1:0] v;
    begin
      case (idx)
        7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
        7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
        7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
        7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
        7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
        7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
        7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
        7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
        7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
        7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
        7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
        7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
        7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
        7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
        7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
        7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
        7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
        7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
        7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
        7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
        7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
        7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
        7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
        7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
        7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
        7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
        7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
        7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
        7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
        7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
        7'd90: v = 16'd32768;
        default: v = 16'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hw/rtl/quadruped_creep_gait_offsets_unit.sv -----
// ----------------------------------------------------------------------------
// quadruped_creep_gait_offsets_unit
// Path: holding register, issue register, geometry stages A to D, divider
// stages E and F, output register. The leg sequencer issues one leg per cycle
// when not stalled, four per request or one for a bad request, and takes the
// next request as the last leg of the current one issues.
// Reset (synchronous, rst_n low): pipeline emptied, registers to defaults.
// ----------------------------------------------------------------------------
module quadruped_creep_gait_offsets_unit #(
  parameter int PHASES = qcg_pkg::PHASES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [qcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qcg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [qcg_pkg::PHASE_W-1:0]       in_phase,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [qcg_pkg::LEG_W-1:0]         out_leg_index,
  output logic signed [qcg_pkg::OFS_W-1:0]  out_offset_x,
  output logic signed [qcg_pkg::OFS_W-1:0]  out_offset_y,
  output logic signed [qcg_pkg::Z_W-1:0]    out_offset_z,
  output logic                              out_bad_request,
  output logic                              out_last_of_run
);
  import qcg_pkg::*;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   en;
  ctl_t                   s1_ctl, n_ctl, q_ctl;
  logic [PHASE_W-1:0]     s1_phase;
  logic signed [N_W-1:0]  nx, ny;
  logic signed [OFS_W-1:0] qx, qy;

  logic                   out_valid_r;
  logic [LEG_W-1:0]       out_leg_r;
  logic signed [OFS_W-1:0] out_x_r, out_y_r;
  logic signed [Z_W-1:0]  out_z_r;
  logic                   out_bad_r, out_last_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WALK_DIR: cfg_nxt.dir  = cfg_wdata[DIR_W-1:0];
        REG_STEP_LEN: cfg_nxt.step = cfg_wdata[STEP_W-1:0];
        REG_LEAN_PAT: cfg_nxt.lean = cfg_wdata[LEAN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir  <= '0;
      cfg_r.step <= '0;
      cfg_r.lean <= LEAN_W'(124);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign en = !out_valid_r || !out_stall;

  qcg_issue #(.PHASES(PHASES)) u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .dir      (cfg_r.dir),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_phase (in_phase),
    .s1_ctl   (s1_ctl),
    .s1_phase (s1_phase)
  );

  qcg_geom #(.PHASES(PHASES)) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .s1_ctl   (s1_ctl),
    .s1_phase (s1_phase),
    .n_ctl    (n_ctl),
    .nx       (nx),
    .ny       (ny)
  );

  qcg_rdiv #(.PHASES(PHASES)) u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .n_ctl (n_ctl),
    .nx    (nx),
    .ny    (ny),
    .q_ctl (q_ctl),
    .qx    (qx),
    .qy    (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_leg_r  <= q_ctl.bad ? '0 : q_ctl.leg;
      out_x_r    <= q_ctl.bad ? '0 : qx;
      out_y_r    <= q_ctl.bad ? '0 : qy;
      out_z_r    <= (q_ctl.lift && !q_ctl.bad) ? Z_W'(LIFT_Z) : '0;
      out_bad_r  <= q_ctl.bad;
      out_last_r <= q_ctl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_leg_index   = out_leg_r;
  assign out_offset_x    = out_x_r;
  assign out_offset_y    = out_y_r;
  assign out_offset_z    = out_z_r;
  assign out_bad_request = out_bad_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- hw/rtl/qcg_issue.sv -----
// ----------------------------------------------------------------------------
// qcg_issue
// Request holding register and leg sequencer: turns one phase request into
// four leg slots, or one slot for a bad request.
// ----------------------------------------------------------------------------
module qcg_issue #(
  parameter int PHASES = qcg_pkg::PHASES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [qcg_pkg::DIR_W-1:0]    dir,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [qcg_pkg::PHASE_W-1:0]  in_phase,
  output qcg_pkg::ctl_t                s1_ctl,
  output logic [qcg_pkg::PHASE_W-1:0]  s1_phase
);
  import qcg_pkg::*;

  localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W+1)'(PHASES);

  logic                 hold_r, hold_nxt;
  logic                 bad_r, bad_nxt;
  logic [LEG_W-1:0]     cnt_r, cnt_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  ctl_t                 s1_ctl_r, s1_ctl_nxt;
  logic [PHASE_W-1:0]   s1_phase_r, s1_phase_nxt;
  logic                 last_issue;
  logic                 accept;

  assign last_issue = bad_r || (cnt_r == 2'd3);
  assign in_stall   = !en || (hold_r && !last_issue);
  assign accept     = in_valid && !in_stall;

  always_comb begin
    hold_nxt     = hold_r;
    bad_nxt      = bad_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    s1_ctl_nxt   = s1_ctl_r;
    s1_phase_nxt = s1_phase_r;
    if (en) begin
      s1_ctl_nxt.valid = hold_r;
      s1_ctl_nxt.bad   = bad_r;
      s1_ctl_nxt.last  = last_issue;
      s1_ctl_nxt.lift  = 1'b0;
      s1_ctl_nxt.leg   = bad_r ? '0 : cnt_r;
      s1_phase_nxt     = phase_r;
      if (hold_r) begin
        cnt_nxt = cnt_r + 2'd1;
        if (last_issue) begin
          hold_nxt = 1'b0;
        end
      end
    end
    if (accept) begin
      hold_nxt  = 1'b1;
      cnt_nxt   = '0;
      phase_nxt = in_phase;
      bad_nxt   = (dir >= DIR_LIMIT) || ({1'b0, in_phase} >= PHASE_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      bad_r    <= 1'b0;
      cnt_r    <= '0;
      s1_ctl_r <= '0;
    end else begin
      hold_r   <= hold_nxt;
      bad_r    <= bad_nxt;
      cnt_r    <= cnt_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    s1_phase_r <= s1_phase_nxt;
  end

  assign s1_ctl   = s1_ctl_r;
  assign s1_phase = s1_phase_r;

endmodule

// ----- hw/rtl/qcg_geom.sv -----
// ----------------------------------------------------------------------------
// qcg_geom
// Leg geometry pipeline: lift order, local phase and stride factor, sine and
// cosine lookup, products and sums giving the unscaled x and y offsets.
// ----------------------------------------------------------------------------
module qcg_geom #(
  parameter int PHASES = qcg_pkg::PHASES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  qcg_pkg::cfg_t                     cfg,
  input  qcg_pkg::ctl_t                     s1_ctl,
  input  logic [qcg_pkg::PHASE_W-1:0]       s1_phase,
  output qcg_pkg::ctl_t                     n_ctl,
  output logic signed [qcg_pkg::N_W-1:0]    nx,
  output logic signed [qcg_pkg::N_W-1:0]    ny
);
  import qcg_pkg::*;

  localparam int SPAN = PHASES - 2;
  localparam logic signed [5:0]     PH_S   = 6'(PHASES);
  localparam logic signed [M_W-1:0] M_LP0  = M_W'(SPAN);
  localparam logic signed [M_W-1:0] M_LP1  = M_W'(2 * SPAN);
  localparam logic signed [11:0]    K_LEAN = 12'(2 * SPAN * LEAN_UNITS);

  function automatic logic [7:0] trig_sel(input logic [9:0] d);
    logic [1:0] q;
    logic [9:0] r;
    logic [6:0] idx;
    begin
      if (d < 10'd90) begin
        q = 2'd0;
        r = d;
      end else if (d < 10'd180) begin
        q = 2'd1;
        r = d - 10'd90;
      end else if (d < 10'd270) begin
        q = 2'd2;
        r = d - 10'd180;
      end else begin
        q = 2'd3;
        r = d - 10'd270;
      end
      idx = q[0] ? 7'(10'd90 - r) : r[6:0];
      return {q[1], idx};
    end
  endfunction

  // stage A
  logic [1:0]            sector;
  logic [3:0]            slot;
  logic signed [5:0]     t0, t1, t2;
  logic [3:0]            lp;
  logic signed [M_W-1:0] m;
  logic [15:0]           lean_ext;
  logic [9:0]            dsum, dcos;
  logic [7:0]            ssel, csel;

  ctl_t                  a_ctl_r, a_ctl_nxt;
  logic                  a_lean_r;
  logic signed [M_W-1:0] a_m_r;
  logic [7:0]            a_ssel_r, a_csel_r;

  always_comb begin
    if (cfg.dir > 9'd315 || cfg.dir < 9'd45) begin
      sector = 2'd0;
    end else if (cfg.dir < 9'd135) begin
      sector = 2'd1;
    end else if (cfg.dir < 9'd225) begin
      sector = 2'd2;
    end else begin
      sector = 2'd3;
    end
    slot = lift_slot(sector, s1_ctl.leg);
    t0 = $signed({2'b00, s1_phase}) - $signed({2'b00, slot});
    t1 = (t0 < 0) ? t0 + PH_S : t0;
    t2 = (t1 < 0) ? t1 + PH_S : t1;
    lp = t2[3:0];
    if (lp == 4'd0) begin
      m = M_LP0;
    end else if (lp == 4'd1) begin
      m = M_LP1;
    end else begin
      m = 6'sd2 - $signed({1'b0, lp, 1'b0});
    end
    lean_ext = {6'd0, cfg.lean};
    dsum = {1'b0, cfg.dir} + 10'd90;
    dcos = (dsum >= 10'd360) ? dsum - 10'd360 : dsum;
    ssel = trig_sel({1'b0, cfg.dir});
    csel = trig_sel(dcos);
    a_ctl_nxt      = s1_ctl;
    a_ctl_nxt.lift = (slot == s1_phase);
  end

  // stage B
  logic [TAB_W-1:0]         s_tab, c_tab;
  logic signed [TRIG_W-1:0] sd, cd;
  logic signed [SM_W-1:0]   sm;

  ctl_t                     b_ctl_r;
  logic                     b_lean_r;
  logic signed [TRIG_W-1:0] b_sd_r, b_cd_r;
  logic signed [SM_W-1:0]   b_sm_r;

  always_comb begin
    s_tab = sine_q15(a_ssel_r[6:0]);
    c_tab = sine_q15(a_csel_r[6:0]);
    sd = a_ssel_r[7] ? -$signed({1'b0, s_tab}) : $signed({1'b0, s_tab});
    cd = a_csel_r[7] ? -$signed({1'b0, c_tab}) : $signed({1'b0, c_tab});
    sm = $signed({1'b0, cfg.step}) * a_m_r;
  end

  // stage C
  logic signed [N_W-1:0]   psx, psy;
  logic signed [28:0]      kc, ks;

  ctl_t                    c_ctl_r;
  logic signed [N_W-1:0]   c_psx_r, c_psy_r, c_lx_r, c_ly_r;

  always_comb begin
    psx = b_sm_r * b_sd_r;
    psy = b_sm_r * b_cd_r;
    kc  = K_LEAN * b_cd_r;
    ks  = K_LEAN * b_sd_r;
  end

  // stage D
  ctl_t                    d_ctl_r;
  logic signed [N_W-1:0]   d_nx_r, d_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
      d_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= a_ctl_r;
      c_ctl_r <= b_ctl_r;
      d_ctl_r <= c_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lean_r <= lean_ext[s1_phase];
      a_m_r    <= m;
      a_ssel_r <= ssel;
      a_csel_r <= csel;
      b_lean_r <= a_lean_r;
      b_sd_r   <= sd;
      b_cd_r   <= cd;
      b_sm_r   <= sm;
      c_psx_r  <= psx;
      c_psy_r  <= psy;
      c_lx_r   <= b_lean_r ? N_W'(kc) : -N_W'(kc);
      c_ly_r   <= b_lean_r ? -N_W'(ks) : N_W'(ks);
      d_nx_r   <= c_lx_r + c_psx_r;
      d_ny_r   <= c_ly_r + c_psy_r;
    end
  end

  assign n_ctl = d_ctl_r;
  assign nx    = d_nx_r;
  assign ny    = d_ny_r;

endmodule

// ----- hw/rtl/qcg_rdiv.sv -----
// ----------------------------------------------------------------------------
// qcg_rdiv
// Two-lane rounding divider by 256*(PHASES-2): magnitude and half-step bias,
// reciprocal multiply, remainder correction and saturation to 18 bits.
// ----------------------------------------------------------------------------
module qcg_rdiv #(
  parameter int PHASES = qcg_pkg::PHASES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  qcg_pkg::ctl_t                     n_ctl,
  input  logic signed [qcg_pkg::N_W-1:0]    nx,
  input  logic signed [qcg_pkg::N_W-1:0]    ny,
  output qcg_pkg::ctl_t                     q_ctl,
  output logic signed [qcg_pkg::OFS_W-1:0]  qx,
  output logic signed [qcg_pkg::OFS_W-1:0]  qy
);
  import qcg_pkg::*;

  localparam int SPAN = PHASES - 2;
  localparam logic [N_W-1:0]     HALF_DEN = N_W'(128 * SPAN);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((1 << RECIP_SHIFT) / SPAN);
  localparam logic [3:0]         SPAN_V   = 4'(SPAN);
  localparam logic [B_W-1:0]     SPAN_B   = B_W'(SPAN);
  localparam logic [Q_W-1:0]     POS_LIM  = Q_W'(131071);
  localparam logic [Q_W-1:0]     NEG_LIM  = Q_W'(131072);

  logic signed [N_W-1:0]       n_in [2];
  logic [N_W-1:0]              mag [2];
  logic [N_W-1:0]              biased [2];
  logic [B_W+RECIP_W-1:0]      prod [2];
  logic [B_W+3:0]              qs [2];
  logic [B_W-1:0]              rem [2];
  logic [Q_W-1:0]              q [2];
  logic signed [OFS_W-1:0]     res [2];

  ctl_t                        e_ctl_r, f_ctl_r;
  logic                        e_neg_r [2];
  logic [B_W-1:0]              e_b_r [2];
  logic                        f_neg_r [2];
  logic [B_W-1:0]              f_b_r [2];
  logic [B_W-1:0]              f_q0_r [2];

  assign n_in[0] = nx;
  assign n_in[1] = ny;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]    = n_in[i][N_W-1] ? N_W'(-n_in[i]) : N_W'(n_in[i]);
      biased[i] = mag[i] + HALF_DEN;
      prod[i]   = e_b_r[i] * RECIP;
      qs[i]     = f_q0_r[i] * SPAN_V;
      rem[i]    = f_b_r[i] - qs[i][B_W-1:0];
      q[i]      = {1'b0, f_q0_r[i]} + ((rem[i] >= SPAN_B) ? Q_W'(1) : Q_W'(0));
      if (!f_neg_r[i]) begin
        res[i] = (q[i] > POS_LIM) ? OFS_W'(POS_LIM) : $signed(q[i][OFS_W-1:0]);
      end else begin
        res[i] = (q[i] > NEG_LIM) ? $signed(NEG_LIM[OFS_W-1:0])
                                  : -$signed(q[i][OFS_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctl_r <= '0;
      f_ctl_r <= '0;
    end else if (en) begin
      e_ctl_r <= n_ctl;
      f_ctl_r <= e_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        e_neg_r[i] <= n_in[i][N_W-1];
        e_b_r[i]   <= biased[i][B_W+7:8];
        f_neg_r[i] <= e_neg_r[i];
        f_b_r[i]   <= e_b_r[i];
        f_q0_r[i]  <= prod[i][B_W+RECIP_W-1:RECIP_SHIFT];
      end
    end
  end

  assign q_ctl = f_ctl_r;
  assign qx    = res[0];
  assign qy    = res[1];

endmodule

// ----- hw/rtl/qcg_checker.sv -----
// ----------------------------------------------------------------------------
// qcg_checker
// Port-level checks on the result channel of the creep gait offset unit.
// ----------------------------------------------------------------------------
module qcg_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [qcg_pkg::LEG_W-1:0]         out_leg_index,
  input  logic signed [qcg_pkg::OFS_W-1:0]  out_offset_x,
  input  logic signed [qcg_pkg::OFS_W-1:0]  out_offset_y,
  input  logic signed [qcg_pkg::Z_W-1:0]    out_offset_z,
  input  logic                              out_bad_request,
  input  logic                              out_last_of_run
);
  import qcg_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_last_of_run && out_leg_index == '0 &&
      out_offset_x == '0 && out_offset_y == '0 && out_offset_z == '0)
    else $error("bad request result not a single cleared result");

  a_last_leg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_request |-> out_last_of_run == (out_leg_index == 2'd3))
    else $error("run end not on the last leg");

  a_lift_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_offset_z == '0 || out_offset_z == Z_W'(LIFT_Z))
    else $error("vertical offset neither rest nor lift");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_offset_x) &&
      $stable(out_offset_y) && $stable(out_leg_index) && $stable(out_last_of_run))
    else $error("stalled result changed");

endmodule

bind quadruped_creep_gait_offsets_unit qcg_checker u_qcg_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the creep gait offset unit by predicting every leg result. Phase
// requests come from a queue and are driven with random gaps, and the result
// side stalls at random, except in steady bursts. A local predictor turns each
// accepted request into its expected leg offsets, and the monitor compares
// each result with them in order. Walk direction, step length and lean pattern
// change between bursts, only while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
  import qcg_pkg::*;

  localparam int GAIT_PHASES = PHASES_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint OFS_MAX = (longint'(1) <<< (OFS_W - 1)) - 1;
  localparam longint OFS_MIN = -(longint'(1) <<< (OFS_W - 1));

  localparam int SINE_TAB [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  localparam int LEG_SLOT [0:3][0:3] = '{
    '{8, 3, 0, 5},
    '{3, 5, 8, 0},
    '{5, 0, 3, 8},
    '{0, 8, 5, 3}
  };

  typedef struct {
    logic [LEG_W-1:0]        leg;
    logic signed [OFS_W-1:0] x;
    logic signed [OFS_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic                    bad;
    logic                    last;
  } leg_offset_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [PHASE_W-1:0]           in_phase = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [LEG_W-1:0]             out_leg_index;
  logic signed [OFS_W-1:0]      out_offset_x;
  logic signed [OFS_W-1:0]      out_offset_y;
  logic signed [Z_W-1:0]        out_offset_z;
  logic                         out_bad_request;
  logic                         out_last_of_run;

  logic [DIR_W-1:0]  walk_dir = '0;
  logic [STEP_W-1:0] step_len = '0;
  logic [LEAN_W-1:0] lean_pat = 10'd124;

  logic [PHASE_W-1:0] phase_requests[$];
  leg_offset_t        leg_offsets_due[$];
  int                 mismatches = 0;
  bit                 steady = 1'b0;
  int                 in_gap = 0;
  int                 stall_left = 0;

  quadruped_creep_gait_offsets_unit #(.PHASES(GAIT_PHASES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_phase        (in_phase),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_leg_index   (out_leg_index),
    .out_offset_x    (out_offset_x),
    .out_offset_y    (out_offset_y),
    .out_offset_z    (out_offset_z),
    .out_bad_request (out_bad_request),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint sine_deg(input int d);
    int q, r;
    longint v;
    d = d % 360;
    q = d / 90;
    r = d % 90;
    v = (q == 1 || q == 3) ? SINE_TAB[90 - r] : SINE_TAB[r];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic logic signed [OFS_W-1:0] round_sat(input longint n, input longint d);
    longint q;
    if (n >= 0) q = (n + d / 2) / d;
    else q = -((-n + d / 2) / d);
    if (q > OFS_MAX) q = OFS_MAX;
    if (q < OFS_MIN) q = OFS_MIN;
    return q[OFS_W-1:0];
  endfunction

  function automatic void predict_leg_offsets(input logic [PHASE_W-1:0] ph);
    leg_offset_t r;
    int dir, sector, slot, lp;
    longint lean, sr, cr, sd, cd, span, m, nx, ny;
    r = '{default: '0};
    dir = int'(walk_dir);
    if (dir >= int'(DIR_LIMIT) || int'(ph) >= GAIT_PHASES) begin
      r.bad = 1'b1;
      r.last = 1'b1;
      leg_offsets_due.push_back(r);
      return;
    end
    if (dir > 315 || dir < 45) sector = 0;
    else if (dir < 135) sector = 1;
    else if (dir < 225) sector = 2;
    else sector = 3;
    lean = (int'(ph) < LEAN_W && lean_pat[ph]) ? 1 : -1;
    sr = sine_deg(dir + 90);
    cr = sine_deg(dir + 180);
    sd = sine_deg(dir);
    cd = sine_deg(dir + 90);
    span = GAIT_PHASES - 2;
    for (int leg = 0; leg < 4; leg++) begin
      slot = LEG_SLOT[sector][leg];
      lp = (int'(ph) + 2 * GAIT_PHASES - slot) % GAIT_PHASES;
      if (lp < 2) m = (lp + 1) * span;
      else m = -2 * (lp - 1);
      nx = 2 * span * lean * LEAN_UNITS * sr + longint'(step_len) * sd * m;
      ny = 2 * span * lean * LEAN_UNITS * cr + longint'(step_len) * cd * m;
      r.leg = leg[LEG_W-1:0];
      r.x = round_sat(nx, 256 * span);
      r.y = round_sat(ny, 256 * span);
      r.z = (slot == int'(ph)) ? LIFT_Z[Z_W-1:0] : '0;
      r.bad = 1'b0;
      r.last = (leg == 3);
      leg_offsets_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_WALK_DIR: walk_dir = data[DIR_W-1:0];
      REG_STEP_LEN: step_len = data[STEP_W-1:0];
      REG_LEAN_PAT: lean_pat = data[LEAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int dir, input int step, input int lean);
    write_reg(REG_WALK_DIR, dir[CFG_DATA_W-1:0]);
    write_reg(REG_STEP_LEN, step[CFG_DATA_W-1:0]);
    write_reg(REG_LEAN_PAT, lean[CFG_DATA_W-1:0]);
  endtask

  task automatic drain();
    @(negedge clk);
    while (phase_requests.size() != 0 || in_valid || leg_offsets_due.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_leg_offsets(in_phase);
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (phase_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_phase <= phase_requests.pop_front();
        in_gap <= steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    leg_offset_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (leg_offsets_due.size() == 0) begin
          report_mismatch("unrequested result, leg", out_leg_index, 0);
        end else begin
          want = leg_offsets_due.pop_front();
          if (out_leg_index !== want.leg) report_mismatch("leg_index", out_leg_index, want.leg);
          if (out_offset_x !== want.x) report_mismatch("offset_x", out_offset_x, want.x);
          if (out_offset_y !== want.y) report_mismatch("offset_y", out_offset_y, want.y);
          if (out_offset_z !== want.z) report_mismatch("offset_z", out_offset_z, want.z);
          if (out_bad_request !== want.bad)
            report_mismatch("bad_request", out_bad_request, want.bad);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int sent, n, start, r, dir, step;
    int borders [0:6];
    int near_borders [0:10];
    borders = '{45, 135, 225, 315, 90, 180, 270};
    near_borders = '{0, 44, 45, 134, 135, 224, 225, 314, 315, 316, 359};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset, every phase plus out-of-range phases
    for (int p = 0; p < GAIT_PHASES; p++) phase_requests.push_back(p[PHASE_W-1:0]);
    phase_requests.push_back(4'd10);
    phase_requests.push_back(4'd15);
    drain();

    set_config(359, 255, 1023);
    write_reg(REG_SPARE, 10'h3FF);
    phase_requests.push_back(4'd0);
    phase_requests.push_back(4'd9);
    phase_requests.push_back(4'd15);
    drain();

    set_config(360, 255, 1023);
    phase_requests.push_back(4'd3);
    drain();
    write_reg(REG_WALK_DIR, 10'h3FF);
    phase_requests.push_back(4'd0);
    drain();

    foreach (borders[i]) begin
      set_config(borders[i], 255, 0);
      phase_requests.push_back(4'd4);
      drain();
    end

    sent = 0;
    while (sent < 200) begin
      r = $urandom_range(0, 99);
      if (r < 10) dir = $urandom_range(360, 1023);
      else if (r < 25) dir = near_borders[$urandom_range(0, 10)];
      else dir = $urandom_range(0, 359);
      r = $urandom_range(0, 99);
      if (r < 15) step = 0;
      else if (r < 30) step = 255;
      else step = $urandom_range(0, 255);
      set_config(dir, step, $urandom_range(0, 1023));
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(6, 16);
      start = $urandom_range(0, GAIT_PHASES - 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 8)
          phase_requests.push_back(PHASE_W'((start + i) % GAIT_PHASES));
        else
          phase_requests.push_back(PHASE_W'($urandom_range(0, 15)));
      end
      sent += n;
      drain();
    end

    repeat (20) @(posedge clk);
    if (leg_offsets_due.size() != 0)
      report_mismatch("results never seen, count", 0, leg_offsets_due.size());
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
